// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the I2C master RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// No dependencies.
package i2cm_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam logic [3:0]  LAST_READ_BIT     = 4'd7;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
    } step_res_t;

endpackage

// ===== rtl/core/i2c_master_byte_engine.sv =====
// I2C master byte engine, one bus timer tick per input item.
// Channels: input items (opcode, write_data, ack_after_read, sda_in) on
// in_valid/in_stall; results (scl_out, sda_out, busy_res, done_res,
// read_data) on out_valid/out_stall; half_period_ticks written on
// cfg_valid/cfg_ready, always ready, to be changed only while idle.
// Every accepted item yields exactly one result, in order.
// Results are registered in the output register, or in the skid register
// while one waits there. Throughput: one item per cycle while in_stall is
// low, the sequencer updating a tick in one pass from its state registers.
// A skid register behind the output register lets one further item in while
// a result waits; in_stall rises only once both entries are full, and drops
// as soon as the receiver takes a result.
// Reset: lines released high, engine idle, shift register and counters
// cleared, half period back to 100 ticks, result buffer empty.
// Depends on i2cm_pkg, i2cm_step and i2cm_skid.
module i2c_master_byte_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [7:0]  write_data,
    input  logic        ack_after_read,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_out,
    output logic        sda_out,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] half_period_ticks
);
    import i2cm_pkg::*;

    logic        half_period_wr;
    logic [15:0] half_period_reg;
    logic        accept;
    logic        buf_full;
    step_res_t   step_res;
    step_res_t   out_res;

    assign cfg_ready      = 1'b1;
    assign half_period_wr = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (half_period_wr)
        begin
            half_period_reg <= half_period_ticks;
        end
    end

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    i2cm_step u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .opcode         (opcode),
        .write_data     (write_data),
        .ack_after_read (ack_after_read),
        .sda_in         (sda_in),
        .half_period    (half_period_reg),
        .res            (step_res)
    );

    i2cm_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_res  (step_res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign scl_out   = out_res.scl;
    assign sda_out   = out_res.sda;
    assign busy_res  = out_res.busy;
    assign done_res  = out_res.done;
    assign read_data = out_res.rdata;

endmodule

// ===== rtl/core/i2cm_step.sv =====
// Per-tick bus sequencer: phase, wait timer, shift register and line levels.
// Depends on i2cm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cm_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [2:0]         opcode,
    input  logic [7:0]         write_data,
    input  logic               ack_after_read,
    input  logic               sda_in,
    input  logic [15:0]        half_period,
    output i2cm_pkg::step_res_t res
);
    import i2cm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_SP3, PH_WLOW, PH_WHIGH,
        PH_WACKH, PH_WACKL, PH_RHI1, PH_RHI2, PH_RLOW, PH_RA1, PH_RA2, PH_RA3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [15:0] wait_reg, wait_next;
    logic [7:0]  shift_reg, shift_next;
    logic        ack_reg, ack_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        done;
    logic [15:0] wait_load;
    logic [15:0] wait_dec;
    logic [3:0]  bit_inc;
    logic [7:0]  sampled;

    assign wait_load = (half_period == '0) ? 16'd1 : half_period;
    assign wait_dec  = (wait_reg != '0) ? (wait_reg - 16'd1) : '0;
    assign bit_inc   = bit_count_reg + 4'd1;
    assign sampled   = {shift_reg[7:1], sda_in};

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        wait_next      = wait_reg;
        shift_next     = shift_reg;
        ack_next       = ack_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        done           = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            unique case (opcode)
                OP_START:
                begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                    phase_next = PH_ST1;
                    wait_next  = wait_load;
                end
                OP_STOP:
                begin
                    phase_next = PH_SP1;
                    wait_next  = wait_load;
                end
                OP_WRITE:
                begin
                    shift_next     = write_data;
                    bit_count_next = '0;
                    scl_next       = 1'b0;
                    phase_next     = PH_WLOW;
                    wait_next      = wait_load;
                end
                OP_READ:
                begin
                    ack_next       = ack_after_read;
                    bit_count_next = '0;
                    sda_next       = 1'b1;
                    scl_next       = 1'b1;
                    phase_next     = PH_RHI1;
                    wait_next      = wait_load;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else
        begin
            wait_next = wait_dec;
            if (wait_dec == '0)
            begin
                // wait expired: make the next group of line changes
                wait_next = wait_load;
                unique case (phase_reg)
                    PH_ST1:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_ST2;
                    end
                    PH_SP1:
                    begin
                        sda_next   = 1'b0;
                        scl_next   = 1'b1;
                        phase_next = PH_SP2;
                    end
                    PH_SP2:
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_SP3;
                    end
                    PH_WLOW:
                    begin
                        sda_next       = shift_reg[7];
                        shift_next     = {shift_reg[6:0], 1'b0};
                        scl_next       = 1'b1;
                        bit_count_next = bit_inc;
                        phase_next     = PH_WHIGH;
                    end
                    PH_WHIGH:
                    begin
                        if (bit_count_reg < BITS_PER_BYTE)
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_WLOW;
                        end
                        else
                        begin
                            // acknowledge clock with the data line released
                            sda_next   = 1'b1;
                            scl_next   = 1'b1;
                            phase_next = PH_WACKH;
                        end
                    end
                    PH_WACKH:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_WACKL;
                    end
                    PH_RHI1:
                    begin
                        shift_next = (bit_count_reg < LAST_READ_BIT)
                                   ? {sampled[6:0], 1'b0} : sampled;
                        phase_next = PH_RHI2;
                    end
                    PH_RHI2:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_RLOW;
                    end
                    PH_RLOW:
                    begin
                        bit_count_next = bit_inc;
                        sda_next       = 1'b1;
                        if (bit_inc < BITS_PER_BYTE)
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_RHI1;
                        end
                        else
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_RA1;
                        end
                    end
                    PH_RA1:
                    begin
                        sda_next   = ~ack_reg;
                        scl_next   = 1'b1;
                        phase_next = PH_RA2;
                    end
                    PH_RA2:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_RA3;
                    end
                    PH_ST2, PH_SP3, PH_WACKL, PH_RA3, PH_IDLE:
                    begin
                        if (phase_reg == PH_ST2)
                        begin
                            sda_next = 1'b0;
                        end
                        if (phase_reg == PH_SP3)
                        begin
                            scl_next = 1'b0;
                        end
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                        wait_next  = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            wait_reg      <= '0;
            shift_reg     <= '0;
            ack_reg       <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            wait_reg      <= wait_next;
            shift_reg     <= shift_next;
            ack_reg       <= ack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
        end
    end

    assign res.scl   = scl_next;
    assign res.sda   = sda_next;
    assign res.busy  = (phase_next != PH_IDLE);
    assign res.done  = done;
    assign res.rdata = shift_next;

    `ASSERT_IMPLY(a_wait_armed, clk, rst_n, phase_reg != PH_IDLE, wait_reg != '0)
    `ASSERT_CLK(a_bit_range, clk, rst_n, bit_count_reg <= BITS_PER_BYTE)
    `ASSERT_NEXT(a_done_idle, clk, rst_n, accept && done, phase_reg == PH_IDLE)

endmodule

// ===== rtl/core/i2cm_skid.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on i2cm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cm_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  i2cm_pkg::step_res_t push_res,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output i2cm_pkg::step_res_t out_res
);
    import i2cm_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    step_res_t out_res_reg, out_res_next;
    step_res_t skid_res_reg, skid_res_next;
    logic      pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                // drain the skid entry first to keep order
                out_res_next    = skid_res_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_res_next   = push_res;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_res_next   = push_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    `ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ASSERT_IMPLY(a_skid_fill_on_stall, clk, rst_n, $rose(skid_valid_reg), $past(out_stall))
    `ASSERT_NEXT(a_no_push_while_full, clk, rst_n, skid_valid_reg && !pop, skid_valid_reg)

endmodule
